@@ sv/ugbp_pkg.sv @@
// shared types and codes of the uniform grid broad phase
package ugbp_pkg;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DROP  = 2'd1;
    localparam logic [1:0] ST_QUERY = 2'd2;

    localparam logic [1:0] CFG_CELL_SIZE = 2'd0;
    localparam logic [1:0] CFG_GRID_COLS = 2'd1;
    localparam logic [1:0] CFG_GRID_ROWS = 2'd2;

    localparam int DIV_STEPS = 17;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SWEEP,
        S_DIV,
        S_SPAN,
        S_INS_RD,
        S_INS_WR,
        S_Q_FRD,
        S_Q_FWAIT,
        S_Q_ERD,
        S_Q_EMARK,
        S_SCAN,
        S_EMIT,
        S_RESP
    } t_state;

endpackage

@@ sv/ugbp_ram.sv @@
// generic single write port ram with registered read
module ugbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/uniform_grid_broadphase_unit.sv @@
// top level of the uniform grid broad phase unit
//
// Requests come in on i_valid/o_ready: clear, insert or query. Each request
// gives one or more results on o_valid/i_ready, the final one marked o_last.
// Configuration writes use i_cfg_valid/o_cfg_ready with i_cfg_index and
// i_cfg_data; the user must make them only while no request is in flight,
// as the unit does not enforce it. One request is worked on at a time.
// Insert and query first run four serial divisions of the circle bounds
// by the cell size. Insert then does a read-modify-write of the cell fill
// memory for each covered cell. Query reads the fill count of each covered
// cell and each stored entry (entry memory read port), then scans the ball
// ids up to the last neighbour and gives one result per neighbour found,
// or a single result when there is none. Clear sweeps the fill memory, one
// cell per cycle. After reset a sweep clears fill counts and owners; no
// request is taken until it ends. A result waits in the output register
// while i_ready is low; the unit holds its walk and takes a new request
// once the last result is loaded.
module uniform_grid_broadphase_unit import ugbp_pkg::*; #(
    parameter int MAX_COLS      = 16,
    parameter int MAX_ROWS      = 16,
    parameter int CELL_CAPACITY = 8,
    parameter int BALL_COUNT    = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [5:0]  i_ball_id,
    input  logic [7:0]  i_owner_id,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [14:0] i_radius,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic        o_found,
    output logic [5:0]  o_neighbour_id,
    output logic [7:0]  o_neighbour_owner,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int NCELLS = MAX_COLS * MAX_ROWS;
    localparam int NENT   = NCELLS * CELL_CAPACITY;
    localparam int CLW    = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int EAW    = (NENT > 1) ? $clog2(NENT) : 1;
    localparam int FW     = $clog2(CELL_CAPACITY + 1);
    localparam int IDW    = $clog2(BALL_COUNT);
    localparam int SWN    = (NCELLS > BALL_COUNT) ? NCELLS : BALL_COUNT;
    localparam int SWW    = $clog2(SWN);

    t_state r_state, n_state;

    logic [15:0] r_cs;
    logic [4:0]  r_cols, r_rows;

    logic [1:0]  r_op;
    logic [5:0]  r_id;
    logic [7:0]  r_own;
    logic signed [15:0] r_px, r_py;
    logic [14:0] r_rad;

    logic [1:0]  r_div_k, n_div_k;
    logic [4:0]  r_div_cnt, n_div_cnt;
    logic [16:0] r_rem, n_rem;
    logic [16:0] r_quo, n_quo;
    logic        r_div_neg, n_div_neg;
    logic [16:0] r_lo, n_lo;
    logic [4:0]  r_c0, n_c0, r_c1, n_c1, r_r0, n_r0, r_r1, n_r1;
    logic        r_empty, n_empty;

    logic [4:0]     r_row, n_row, r_col, n_col;
    logic [CLW-1:0] r_base, n_base;
    logic [FW-1:0]  r_nent, n_nent, r_e, n_e;
    logic           r_drop, n_drop;
    logic [BALL_COUNT-1:0] r_seen, n_seen;
    logic [IDW-1:0] r_bit, n_bit;
    logic [SWW-1:0] r_sw_cnt, n_sw_cnt;
    logic           r_sw_own, n_sw_own;

    logic        r_o_valid, n_o_valid;
    logic [1:0]  r_o_status, n_o_status;
    logic        r_o_found, n_o_found;
    logic [5:0]  r_o_nid, n_o_nid;
    logic [7:0]  r_o_nown, n_o_nown;
    logic        r_o_last, n_o_last;

    // ram ports
    logic            fill_we, fill_re;
    logic [CLW-1:0]  fill_waddr, fill_raddr;
    logic [FW-1:0]   fill_wdata, fill_rdata;
    logic            ent_we, ent_re;
    logic [EAW-1:0]  ent_waddr, ent_raddr;
    logic [5:0]      ent_rdata;
    logic            own_we, own_re;
    logic [IDW-1:0]  own_waddr, own_raddr;
    logic [7:0]      own_wdata, own_rdata;

    ugbp_ram #(.WIDTH(FW), .DEPTH(NCELLS)) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (fill_we),
        .i_waddr (fill_waddr),
        .i_wdata (fill_wdata),
        .i_re    (fill_re),
        .i_raddr (fill_raddr),
        .o_rdata (fill_rdata)
    );

    ugbp_ram #(.WIDTH(6), .DEPTH(NENT)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (r_id),
        .i_re    (ent_re),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    ugbp_ram #(.WIDTH(8), .DEPTH(BALL_COUNT)) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (own_we),
        .i_waddr (own_waddr),
        .i_wdata (own_wdata),
        .i_re    (own_re),
        .i_raddr (own_raddr),
        .o_rdata (own_rdata)
    );

    // shared helpers
    logic        out_free;
    logic [15:0] cs_eff;
    logic [4:0]  ncol, nrow, n_cur, nm1;
    logic signed [15:0] pos_sel;
    logic signed [17:0] bound;
    logic [17:0] bound_mag;
    logic [16:0] rem_sh, quo_nx;
    logic        ge, div_last;
    logic [16:0] hi_full;
    logic        span_empty;
    logic [CLW-1:0] cell_idx;
    logic [EAW-1:0] ent_addr;
    logic        walk_end, ent_end, id_ok, seen_last;
    logic [BALL_COUNT-1:0] seen_clr;

    assign out_free = !r_o_valid || i_ready;
    assign cs_eff   = (r_cs == 16'd0) ? 16'd1 : r_cs;
    assign ncol     = (32'(r_cols) > MAX_COLS) ? 5'(MAX_COLS) : r_cols;
    assign nrow     = (32'(r_rows) > MAX_ROWS) ? 5'(MAX_ROWS) : r_rows;

    assign pos_sel   = r_div_k[1] ? r_py : r_px;
    assign bound     = r_div_k[0] ? (18'(pos_sel) + $signed({3'b0, r_rad}))
                                  : (18'(pos_sel) - $signed({3'b0, r_rad}));
    assign bound_mag = bound[17] ? 18'(-bound) : 18'(bound);

    assign rem_sh   = {r_rem[15:0], r_quo[16]};
    assign ge       = rem_sh >= {1'b0, cs_eff};
    assign quo_nx   = {r_quo[15:0], ge};
    assign div_last = 32'(r_div_cnt) == DIV_STEPS;

    assign n_cur      = r_div_k[1] ? nrow : ncol;
    assign nm1        = n_cur - 5'd1;
    assign hi_full    = (quo_nx > {12'b0, nm1}) ? {12'b0, nm1} : quo_nx;
    assign span_empty = (n_cur == 5'd0) || (r_div_neg && quo_nx != 17'd0) || (r_lo > hi_full);

    assign cell_idx  = CLW'(r_base + CLW'(r_col));
    assign ent_addr  = EAW'(32'(cell_idx) * CELL_CAPACITY + 32'(r_e));
    assign walk_end  = (r_col == r_c1) && (r_row == r_r1);
    assign ent_end   = (r_e + FW'(1)) == r_nent;
    assign id_ok     = 32'(r_id) < BALL_COUNT;
    assign seen_clr  = r_seen & ~(BALL_COUNT'(1) << r_bit);
    assign seen_last = seen_clr == '0;

    assign o_ready     = r_state == S_IDLE;
    assign o_cfg_ready = 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    priority if (i_operation == OP_CLEAR) n_state = S_SWEEP;
                    else if (i_operation == OP_INSERT || i_operation == OP_QUERY)
                        n_state = S_DIV;
                    else n_state = S_RESP;
                end
            end
            S_SWEEP: begin
                if (32'(r_sw_cnt) == SWN - 1) n_state = r_sw_own ? S_IDLE : S_RESP;
            end
            S_DIV: begin
                if (div_last && r_div_k == 2'd3) n_state = S_SPAN;
            end
            S_SPAN: begin
                if (r_op == OP_INSERT) n_state = (!id_ok || r_empty) ? S_RESP : S_INS_RD;
                else n_state = r_empty ? S_SCAN : S_Q_FRD;
            end
            S_INS_RD:  n_state = S_INS_WR;
            S_INS_WR:  n_state = walk_end ? S_RESP : S_INS_RD;
            S_Q_FRD:   n_state = S_Q_FWAIT;
            S_Q_FWAIT: begin
                if (fill_rdata != '0) n_state = S_Q_ERD;
                else n_state = walk_end ? S_SCAN : S_Q_FRD;
            end
            S_Q_ERD:   n_state = S_Q_EMARK;
            S_Q_EMARK: begin
                if (!ent_end) n_state = S_Q_ERD;
                else n_state = walk_end ? S_SCAN : S_Q_FRD;
            end
            S_SCAN: begin
                priority if (r_seen == '0) begin
                    if (out_free) n_state = S_IDLE;
                end else if (r_seen[r_bit]) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) n_state = seen_last ? S_IDLE : S_SCAN;
            end
            S_RESP: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_div_k   = r_div_k;
        n_div_cnt = r_div_cnt;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_div_neg = r_div_neg;
        n_lo      = r_lo;
        n_c0      = r_c0;
        n_c1      = r_c1;
        n_r0      = r_r0;
        n_r1      = r_r1;
        n_empty   = r_empty;
        n_row     = r_row;
        n_col     = r_col;
        n_base    = r_base;
        n_nent    = r_nent;
        n_e       = r_e;
        n_drop    = r_drop;
        n_seen    = r_seen;
        n_bit     = r_bit;
        n_sw_cnt  = r_sw_cnt;
        n_sw_own  = r_sw_own;

        n_o_valid  = r_o_valid && !i_ready;
        n_o_status = r_o_status;
        n_o_found  = r_o_found;
        n_o_nid    = r_o_nid;
        n_o_nown   = r_o_nown;
        n_o_last   = r_o_last;

        fill_we    = 1'b0;
        fill_waddr = cell_idx;
        fill_wdata = '0;
        fill_re    = 1'b0;
        fill_raddr = cell_idx;
        ent_we     = 1'b0;
        ent_waddr  = EAW'(32'(cell_idx) * CELL_CAPACITY + 32'(fill_rdata));
        ent_re     = 1'b0;
        ent_raddr  = ent_addr;
        own_we     = 1'b0;
        own_waddr  = r_id[IDW-1:0];
        own_wdata  = r_own;
        own_re     = 1'b0;
        own_raddr  = r_bit;

        unique case (r_state)
            S_IDLE: begin
                n_div_k   = 2'd0;
                n_div_cnt = 5'd0;
                n_empty   = 1'b0;
                n_drop    = 1'b0;
                n_sw_cnt  = '0;
                n_sw_own  = 1'b0;
            end
            S_SWEEP: begin
                fill_we    = 32'(r_sw_cnt) < NCELLS;
                fill_waddr = CLW'(r_sw_cnt);
                own_we     = r_sw_own && (32'(r_sw_cnt) < BALL_COUNT);
                own_waddr  = IDW'(r_sw_cnt);
                own_wdata  = 8'd0;
                n_sw_cnt   = SWW'(r_sw_cnt + SWW'(1));
            end
            S_DIV: begin
                if (r_div_cnt == 5'd0) begin
                    n_div_neg = bound[17];
                    n_rem     = 17'd0;
                    n_quo     = bound_mag[16:0];
                    n_div_cnt = 5'd1;
                end else begin
                    n_rem     = ge ? (rem_sh - {1'b0, cs_eff}) : rem_sh;
                    n_quo     = quo_nx;
                    n_div_cnt = div_last ? 5'd0 : (r_div_cnt + 5'd1);
                    if (div_last) begin
                        n_div_k = r_div_k + 2'd1;
                        if (!r_div_k[0]) begin
                            n_lo = r_div_neg ? 17'd0 : quo_nx;
                        end else begin
                            n_empty = r_empty || span_empty;
                            if (r_div_k[1]) begin
                                n_r0 = r_lo[4:0];
                                n_r1 = hi_full[4:0];
                            end else begin
                                n_c0 = r_lo[4:0];
                                n_c1 = hi_full[4:0];
                            end
                        end
                    end
                end
            end
            S_SPAN: begin
                n_row  = r_r0;
                n_col  = r_c0;
                n_base = CLW'(CLW'(r_r0) * CLW'(ncol));
                n_seen = '0;
                n_bit  = '0;
                own_we = (r_op == OP_INSERT) && id_ok;
            end
            S_INS_RD: begin
                fill_re = 1'b1;
            end
            S_INS_WR: begin
                if (32'(fill_rdata) < CELL_CAPACITY) begin
                    ent_we     = 1'b1;
                    fill_we    = 1'b1;
                    fill_wdata = fill_rdata + FW'(1);
                end else begin
                    n_drop = 1'b1;
                end
            end
            S_Q_FRD: begin
                fill_re = 1'b1;
            end
            S_Q_FWAIT: begin
                n_nent = fill_rdata;
                n_e    = '0;
            end
            S_Q_ERD: begin
                ent_re = 1'b1;
            end
            S_Q_EMARK: begin
                if (ent_rdata != r_id) n_seen[ent_rdata[IDW-1:0]] = 1'b1;
                n_e = r_e + FW'(1);
            end
            S_SCAN: begin
                priority if (r_seen == '0) begin
                    if (out_free) begin
                        n_o_valid  = 1'b1;
                        n_o_status = ST_QUERY;
                        n_o_found  = 1'b0;
                        n_o_nid    = 6'd0;
                        n_o_nown   = 8'd0;
                        n_o_last   = 1'b1;
                    end
                end else if (r_seen[r_bit]) begin
                    own_re = 1'b1;
                end else begin
                    n_bit = r_bit + IDW'(1);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = ST_QUERY;
                    n_o_found  = 1'b1;
                    n_o_nid    = 6'(r_bit);
                    n_o_nown   = own_rdata;
                    n_o_last   = seen_last;
                    n_seen     = seen_clr;
                    n_bit      = r_bit + IDW'(1);
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_drop ? ST_DROP : ST_OK;
                    n_o_found  = 1'b0;
                    n_o_nid    = 6'd0;
                    n_o_nown   = 8'd0;
                    n_o_last   = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // cell walk, row major
        if ((r_state == S_INS_WR)
            || (r_state == S_Q_FWAIT && fill_rdata == '0)
            || (r_state == S_Q_EMARK && ent_end)) begin
            if (r_col != r_c1) begin
                n_col = r_col + 5'd1;
            end else begin
                n_col  = r_c0;
                n_row  = r_row + 5'd1;
                n_base = CLW'(r_base + CLW'(ncol));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_SWEEP;
            r_sw_cnt  <= '0;
            r_sw_own  <= 1'b1;
            r_o_valid <= 1'b0;
            r_cs      <= 16'd1024;
            r_cols    <= 5'd16;
            r_rows    <= 5'd16;
        end else begin
            r_state   <= n_state;
            r_sw_cnt  <= n_sw_cnt;
            r_sw_own  <= n_sw_own;
            r_o_valid <= n_o_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_CELL_SIZE: r_cs   <= i_cfg_data;
                    CFG_GRID_COLS: r_cols <= i_cfg_data[4:0];
                    CFG_GRID_ROWS: r_rows <= i_cfg_data[4:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_op  <= i_operation;
            r_id  <= i_ball_id;
            r_own <= i_owner_id;
            r_px  <= i_pos_x;
            r_py  <= i_pos_y;
            r_rad <= i_radius;
        end
        r_div_k    <= n_div_k;
        r_div_cnt  <= n_div_cnt;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_div_neg  <= n_div_neg;
        r_lo       <= n_lo;
        r_c0       <= n_c0;
        r_c1       <= n_c1;
        r_r0       <= n_r0;
        r_r1       <= n_r1;
        r_empty    <= n_empty;
        r_row      <= n_row;
        r_col      <= n_col;
        r_base     <= n_base;
        r_nent     <= n_nent;
        r_e        <= n_e;
        r_drop     <= n_drop;
        r_seen     <= n_seen;
        r_bit      <= n_bit;
        r_o_status <= n_o_status;
        r_o_found  <= n_o_found;
        r_o_nid    <= n_o_nid;
        r_o_nown   <= n_o_nown;
        r_o_last   <= n_o_last;
    end

    assign o_valid           = r_o_valid;
    assign o_status          = r_o_status;
    assign o_found           = r_o_found;
    assign o_neighbour_id    = r_o_nid;
    assign o_neighbour_owner = r_o_nown;
    assign o_last            = r_o_last;

endmodule
